FILE: rtl/ssp_pkg.sv
// Shared types and constants of the servo status packet parser.
package ssp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'hFF;
  localparam logic [BYTE_W-1:0] MIN_LENGTH   = 8'd2;
  localparam logic [BYTE_W-1:0] DEV_ID_RESET = 8'd1;

  // Register index decoded from the word address.
  localparam logic REG_DEV_ID = 1'b0;

  // Result kinds.
  localparam logic KIND_PARAM = 1'b0;
  localparam logic KIND_END   = 1'b1;

  // End-of-packet status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HEADER   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CHECKSUM = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DEVICE   = 2'd3;

  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   param_byte;
    logic [STATUS_W-1:0] status_code;
    logic [BYTE_W-1:0]   device_error;
    logic [BYTE_W-1:0]   packet_id;
  } ssp_result_t;

endpackage

FILE: rtl/ssp_parser.sv
// Packet framing state and per-byte result logic of the status packet parser.
module ssp_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         byte_fire,
  input  logic [ssp_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [ssp_pkg::BYTE_W-1:0]   dev_id,
  output logic                         res_valid,
  output ssp_pkg::ssp_result_t         res
);

  localparam logic [ssp_pkg::PHASE_W-1:0] PH_HUNT  = 3'd0;
  localparam logic [ssp_pkg::PHASE_W-1:0] PH_ID    = 3'd1;
  localparam logic [ssp_pkg::PHASE_W-1:0] PH_LEN   = 3'd2;
  localparam logic [ssp_pkg::PHASE_W-1:0] PH_ERR   = 3'd3;
  localparam logic [ssp_pkg::PHASE_W-1:0] PH_PARAM = 3'd4;
  localparam logic [ssp_pkg::PHASE_W-1:0] PH_CSUM  = 3'd5;

  logic [ssp_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic                        last_ff_r, last_ff_nxt;
  logic [ssp_pkg::BYTE_W-1:0]  id_r, id_nxt;
  logic [ssp_pkg::BYTE_W-1:0]  len_r, len_nxt;
  logic [ssp_pkg::BYTE_W-1:0]  err_r, err_nxt;
  logic [ssp_pkg::BYTE_W-1:0]  sum_r, sum_nxt;
  logic [ssp_pkg::BYTE_W-1:0]  left_r, left_nxt;
  logic [ssp_pkg::BYTE_W-1:0]  sum_add;
  logic [ssp_pkg::BYTE_W-1:0]  left_dec;
  logic [ssp_pkg::BYTE_W-1:0]  params_len;

  assign sum_add    = sum_r + rx_byte;
  assign left_dec   = left_r - 8'd1;
  assign params_len = len_r - ssp_pkg::MIN_LENGTH;

  always_comb begin
    phase_nxt   = phase_r;
    last_ff_nxt = last_ff_r;
    id_nxt      = id_r;
    len_nxt     = len_r;
    err_nxt     = err_r;
    sum_nxt     = sum_r;
    left_nxt    = left_r;
    res_valid   = 1'b0;
    res.kind         = ssp_pkg::KIND_END;
    res.param_byte   = '0;
    res.status_code  = ssp_pkg::ST_OK;
    res.device_error = err_r;
    res.packet_id    = id_r;
    unique case (phase_r)
      PH_HUNT: begin
        if (last_ff_r && rx_byte == ssp_pkg::SYNC_BYTE) begin
          last_ff_nxt = 1'b0;
          phase_nxt   = PH_ID;
        end else begin
          last_ff_nxt = (rx_byte == ssp_pkg::SYNC_BYTE);
        end
      end
      PH_ID: begin
        id_nxt    = rx_byte;
        sum_nxt   = rx_byte;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt   = rx_byte;
        sum_nxt   = sum_add;
        phase_nxt = PH_ERR;
      end
      PH_ERR: begin
        err_nxt = rx_byte;
        sum_nxt = sum_add;
        res.device_error = rx_byte;
        if (id_r != dev_id || len_r < ssp_pkg::MIN_LENGTH) begin
          res_valid       = 1'b1;
          res.status_code = ssp_pkg::ST_HEADER;
          phase_nxt       = PH_HUNT;
          last_ff_nxt     = 1'b0;
        end else begin
          left_nxt  = params_len;
          phase_nxt = (params_len != '0) ? PH_PARAM : PH_CSUM;
        end
      end
      PH_PARAM: begin
        sum_nxt        = sum_add;
        left_nxt       = left_dec;
        res_valid      = 1'b1;
        res.kind       = ssp_pkg::KIND_PARAM;
        res.param_byte = rx_byte;
        if (left_dec == '0) begin
          phase_nxt = PH_CSUM;
        end
      end
      PH_CSUM: begin
        res_valid = 1'b1;
        if (rx_byte != ~sum_r) begin
          res.status_code = ssp_pkg::ST_CHECKSUM;
        end else if (err_r != '0) begin
          res.status_code = ssp_pkg::ST_DEVICE;
        end else begin
          res.status_code = ssp_pkg::ST_OK;
        end
        phase_nxt   = PH_HUNT;
        last_ff_nxt = 1'b0;
      end
      default: begin
        phase_nxt   = PH_HUNT;
        last_ff_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      last_ff_r <= 1'b0;
      id_r      <= '0;
      len_r     <= '0;
      err_r     <= '0;
      sum_r     <= '0;
      left_r    <= '0;
    end else if (byte_fire) begin
      phase_r   <= phase_nxt;
      last_ff_r <= last_ff_nxt;
      id_r      <= id_nxt;
      len_r     <= len_nxt;
      err_r     <= err_nxt;
      sum_r     <= sum_nxt;
      left_r    <= left_nxt;
    end
  end

endmodule

FILE: rtl/ssp_out_buf.sv
// Result register with a skid stage in front of the output channel.
module ssp_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ssp_pkg::ssp_result_t push_data,
  output logic                 can_push,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ssp_pkg::ssp_result_t out_data
);

  logic                 head_vld_r, head_vld_nxt;
  logic                 skid_vld_r, skid_vld_nxt;
  ssp_pkg::ssp_result_t head_r, head_nxt;
  ssp_pkg::ssp_result_t skid_r, skid_nxt;
  logic                 pop;

  assign pop       = head_vld_r && out_ready;
  assign can_push  = !skid_vld_r;
  assign out_valid = head_vld_r;
  assign out_data  = head_r;

  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      if (pop) begin
        head_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (head_vld_r && !pop) begin
        skid_nxt     = push_data;
        skid_vld_nxt = 1'b1;
      end else begin
        head_nxt     = push_data;
        head_vld_nxt = 1'b1;
      end
    end else if (pop) begin
      head_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

FILE: rtl/servo_status_packet_parser.sv
// Top level of the servo bus status packet parser: APB register, parser and result buffer.
// A result caused by a byte is registered in the result buffer before the out_ ports.
// Throughput: one byte per cycle while in_ready is high; framing is one registered pass.
// in_ready falls only when both the result register and its skid stage hold results.
// Reset (rst_n, synchronous, active low): sync hunt, device id back to 1, buffer empty.
module servo_status_packet_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  // Received byte channel.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ssp_pkg::BYTE_W-1:0]   in_rx_byte,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_kind,
  output logic [ssp_pkg::BYTE_W-1:0]   out_param_byte,
  output logic [ssp_pkg::STATUS_W-1:0] out_status_code,
  output logic [ssp_pkg::BYTE_W-1:0]   out_device_error,
  output logic [ssp_pkg::BYTE_W-1:0]   out_packet_id,
  // Configuration port.
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [ssp_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [ssp_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [ssp_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  logic [ssp_pkg::BYTE_W-1:0] dev_id_r;
  logic                       cfg_wr;
  logic                       reg_sel;
  logic                       byte_fire;
  logic                       res_valid;
  logic                       can_push;
  ssp_pkg::ssp_result_t       res;
  ssp_pkg::ssp_result_t       out_data;

  // The single register sits at byte address 0; the top address bit selects the
  // word, the low two bits select a byte lane and are ignored.
  assign reg_sel    = cfg_paddr[ssp_pkg::APB_AW-1];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_id_r <= ssp_pkg::DEV_ID_RESET;
    end else if (cfg_wr && reg_sel == ssp_pkg::REG_DEV_ID) begin
      dev_id_r <= cfg_pwdata[ssp_pkg::BYTE_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_sel == ssp_pkg::REG_DEV_ID) begin
      cfg_prdata = {{(ssp_pkg::APB_DW-ssp_pkg::BYTE_W){1'b0}}, dev_id_r};
    end
  end

  // A byte is taken whenever the skid stage is free, so a result can always be
  // parked even while the one before it is still waiting on the output side.
  assign in_ready  = can_push;
  assign byte_fire = in_valid && in_ready;

  ssp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_fire   (byte_fire),
    .rx_byte     (in_rx_byte),
    .dev_id      (dev_id_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  ssp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (byte_fire && res_valid),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_kind         = out_data.kind;
  assign out_param_byte   = out_data.param_byte;
  assign out_status_code  = out_data.status_code;
  assign out_device_error = out_data.device_error;
  assign out_packet_id    = out_data.packet_id;

endmodule
